// ===== rtl/lpw_pkg.sv =====
// Package for the line pixel walker: shared constants, request and direction codes,
// and the flag group that travels with each result.
// No dependencies.
package lpw_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int COLOR_BITS     = 32;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    DIR_RIGHT_DOWN = 2'd0,
    DIR_RIGHT_UP   = 2'd1,
    DIR_LEFT_DOWN  = 2'd2,
    DIR_LEFT_UP    = 2'd3
  } dir_case_t;

  typedef struct packed {
    logic pixel_valid;
    logic last_pixel;
  } res_flags_t;

endpackage

// ===== rtl/lpw_step.sv =====
// Combinational step logic of the line pixel walker: picks the direction case on a start
// request, emits the current pixel and computes the next position and error term.
// Depends on lpw_pkg.
module lpw_step import lpw_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          req_type,
  input  logic signed [COORD_BITS-1:0]  start_x,
  input  logic signed [COORD_BITS-1:0]  start_y,
  input  logic signed [COORD_BITS-1:0]  end_x,
  input  logic signed [COORD_BITS-1:0]  end_y,
  input  logic [COLOR_BITS-1:0]         line_color,
  input  logic signed [COORD_BITS-1:0]  cur_x,
  input  logic signed [COORD_BITS-1:0]  cur_y,
  input  logic signed [COORD_BITS-1:0]  target_x,
  input  logic signed [COORD_BITS-1:0]  target_y,
  input  logic signed [COORD_BITS:0]    dx,
  input  logic signed [COORD_BITS:0]    dy,
  input  logic signed [2*COORD_BITS+3:0] err,
  input  dir_case_t                     dcase,
  input  logic [COLOR_BITS-1:0]         held_color,
  input  logic                          line_active,
  output logic signed [COORD_BITS-1:0]  cur_x_next,
  output logic signed [COORD_BITS-1:0]  cur_y_next,
  output logic signed [COORD_BITS-1:0]  target_x_next,
  output logic signed [COORD_BITS-1:0]  target_y_next,
  output logic signed [COORD_BITS:0]    dx_next,
  output logic signed [COORD_BITS:0]    dy_next,
  output logic signed [2*COORD_BITS+3:0] err_next,
  output dir_case_t                     dcase_next,
  output logic [COLOR_BITS-1:0]         held_color_next,
  output logic                          line_active_next,
  output res_flags_t                    flags,
  output logic signed [COORD_BITS-1:0]  pixel_x,
  output logic signed [COORD_BITS-1:0]  pixel_y,
  output logic [COLOR_BITS-1:0]         pixel_color
);

  localparam int DW = COORD_BITS + 1;
  localparam int EW = 2 * COORD_BITS + 4;

  logic                   is_start;
  dir_case_t              start_case;
  logic signed [DW-1:0]   start_dx;
  logic signed [DW-1:0]   start_dy;
  logic signed [COORD_BITS-1:0] sel_x;
  logic signed [COORD_BITS-1:0] sel_y;
  logic signed [COORD_BITS-1:0] sel_tx;
  logic signed [COORD_BITS-1:0] sel_ty;
  logic signed [DW-1:0]   sel_dx;
  logic signed [DW-1:0]   sel_dy;
  logic signed [EW-1:0]   sel_err;
  dir_case_t              sel_case;
  logic [COLOR_BITS-1:0]  sel_color;
  logic                   sel_active;
  logic signed [EW-1:0]   dx_e;
  logic signed [EW-1:0]   dy_e;
  logic signed [EW-1:0]   neg_dx_e;
  logic                   err_nonneg;
  logic                   step_x;
  logic                   x_fwd;
  logic                   y_fwd;
  logic signed [DW-1:0]   x_e;
  logic signed [DW-1:0]   y_e;
  logic signed [DW-1:0]   tx_e;
  logic signed [DW-1:0]   ty_e;
  logic signed [DW-1:0]   nx;
  logic signed [DW-1:0]   ny;
  logic signed [EW-1:0]   err_step;
  logic                   in_box;

  assign is_start = (req_type == REQ_START);
  assign start_dx = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
  assign start_dy = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};

  always_comb begin
    if (start_y <= end_y && start_x <= end_x) begin
      start_case = DIR_RIGHT_DOWN;
    end else if (start_y >= end_y && start_x <= end_x) begin
      start_case = DIR_RIGHT_UP;
    end else if (start_y <= end_y) begin
      start_case = DIR_LEFT_DOWN;
    end else begin
      start_case = DIR_LEFT_UP;
    end
  end

  assign sel_x      = is_start ? start_x    : cur_x;
  assign sel_y      = is_start ? start_y    : cur_y;
  assign sel_tx     = is_start ? end_x      : target_x;
  assign sel_ty     = is_start ? end_y      : target_y;
  assign sel_dx     = is_start ? start_dx   : dx;
  assign sel_dy     = is_start ? start_dy   : dy;
  assign sel_err    = is_start ? '0         : err;
  assign sel_case   = is_start ? start_case : dcase;
  assign sel_color  = is_start ? line_color : held_color;
  assign sel_active = is_start | line_active;

  assign dx_e       = {{(EW-DW){sel_dx[DW-1]}}, sel_dx};
  assign dy_e       = {{(EW-DW){sel_dy[DW-1]}}, sel_dy};
  assign neg_dx_e   = -dx_e;
  assign err_nonneg = !sel_err[EW-1];

  always_comb begin
    case (sel_case)
      DIR_RIGHT_DOWN: step_x = (sel_dx != '0) && err_nonneg && (sel_err <= dx_e);
      DIR_RIGHT_UP:   step_x = (sel_dx != '0) && err_nonneg && (sel_err < dx_e);
      default:        step_x = (sel_dx != '0) && err_nonneg && (sel_err <= neg_dx_e);
    endcase
  end

  assign x_fwd = (sel_case == DIR_RIGHT_DOWN) || (sel_case == DIR_RIGHT_UP);
  assign y_fwd = (sel_case == DIR_RIGHT_DOWN) || (sel_case == DIR_LEFT_DOWN);

  assign x_e  = {sel_x[COORD_BITS-1], sel_x};
  assign y_e  = {sel_y[COORD_BITS-1], sel_y};
  assign tx_e = {sel_tx[COORD_BITS-1], sel_tx};
  assign ty_e = {sel_ty[COORD_BITS-1], sel_ty};

  always_comb begin
    nx = x_e;
    ny = y_e;
    if (step_x) begin
      nx       = x_fwd ? x_e + DW'(1) : x_e - DW'(1);
      err_step = x_fwd ? sel_err + dy_e : sel_err - dy_e;
    end else begin
      ny       = y_fwd ? y_e + DW'(1) : y_e - DW'(1);
      err_step = y_fwd ? sel_err - dx_e : sel_err + dx_e;
    end
  end

  always_comb begin
    case (sel_case)
      DIR_RIGHT_DOWN: in_box = (ny <= ty_e) && (nx <= tx_e);
      DIR_RIGHT_UP:   in_box = (ny >= ty_e) && (nx <= tx_e);
      DIR_LEFT_DOWN:  in_box = (ny <= ty_e) && (nx >= tx_e);
      default:        in_box = (ny >= ty_e) && (nx >= tx_e);
    endcase
  end

  always_comb begin
    if (sel_active) begin
      flags.pixel_valid = 1'b1;
      flags.last_pixel  = !in_box;
      pixel_x           = sel_x;
      pixel_y           = sel_y;
      pixel_color       = sel_color;
      cur_x_next        = in_box ? nx[COORD_BITS-1:0] : sel_x;
      cur_y_next        = in_box ? ny[COORD_BITS-1:0] : sel_y;
      err_next          = in_box ? err_step : sel_err;
      line_active_next  = in_box;
    end else begin
      flags.pixel_valid = 1'b0;
      flags.last_pixel  = 1'b0;
      pixel_x           = '0;
      pixel_y           = '0;
      pixel_color       = '0;
      cur_x_next        = cur_x;
      cur_y_next        = cur_y;
      err_next          = err;
      line_active_next  = line_active;
    end
  end

  assign target_x_next   = sel_tx;
  assign target_y_next   = sel_ty;
  assign dx_next         = sel_dx;
  assign dy_next         = sel_dy;
  assign dcase_next      = sel_case;
  assign held_color_next = sel_color;

endmodule

// ===== rtl/lpw_result_reg.sv =====
// Result register of the line pixel walker: holds one finished pixel until it is taken.
// Depends on lpw_pkg.
module lpw_result_reg import lpw_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  res_flags_t                   flags_in,
  input  logic signed [COORD_BITS-1:0] x_in,
  input  logic signed [COORD_BITS-1:0] y_in,
  input  logic [COLOR_BITS-1:0]        color_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output res_flags_t                   flags,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic [COLOR_BITS-1:0]        pixel_color
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      flags       <= flags_in;
      pixel_x     <= x_in;
      pixel_y     <= y_in;
      pixel_color <= color_in;
    end
  end

endmodule

// ===== rtl/line_pixel_walker_top.sv =====
// Top level of the line pixel walker: walk state registers, step logic and result register.
// Depends on lpw_pkg, lpw_step and lpw_result_reg.
// A request's pixel appears at the outputs in the cycle after the request is accepted.
// Throughput: one request per cycle when not stalled; the error-term update is combinational.
// A new request is taken whenever the result register is empty or is being read.
// Reset clears the active-line flag and the result valid; no line is in progress after reset.
module line_pixel_walker_top import lpw_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         req_type,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic [COLOR_BITS-1:0]        line_color,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         pixel_valid,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic [COLOR_BITS-1:0]        pixel_color,
  output logic                         last_pixel
);

  logic                          in_fire;
  logic signed [COORD_BITS-1:0]  cur_x, cur_x_next;
  logic signed [COORD_BITS-1:0]  cur_y, cur_y_next;
  logic signed [COORD_BITS-1:0]  target_x, target_x_next;
  logic signed [COORD_BITS-1:0]  target_y, target_y_next;
  logic signed [COORD_BITS:0]    dx, dx_next;
  logic signed [COORD_BITS:0]    dy, dy_next;
  logic signed [2*COORD_BITS+3:0] err, err_next;
  dir_case_t                     dcase, dcase_next;
  logic [COLOR_BITS-1:0]         held_color, held_color_next;
  logic                          line_active, line_active_next;
  res_flags_t                    step_flags;
  res_flags_t                    out_flags;
  logic signed [COORD_BITS-1:0]  step_x_pix;
  logic signed [COORD_BITS-1:0]  step_y_pix;
  logic [COLOR_BITS-1:0]         step_color;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  lpw_step #(
    .COORD_BITS(COORD_BITS)
  ) u_step (
    .req_type         (req_type),
    .start_x          (start_x),
    .start_y          (start_y),
    .end_x            (end_x),
    .end_y            (end_y),
    .line_color       (line_color),
    .cur_x            (cur_x),
    .cur_y            (cur_y),
    .target_x         (target_x),
    .target_y         (target_y),
    .dx               (dx),
    .dy               (dy),
    .err              (err),
    .dcase            (dcase),
    .held_color       (held_color),
    .line_active      (line_active),
    .cur_x_next       (cur_x_next),
    .cur_y_next       (cur_y_next),
    .target_x_next    (target_x_next),
    .target_y_next    (target_y_next),
    .dx_next          (dx_next),
    .dy_next          (dy_next),
    .err_next         (err_next),
    .dcase_next       (dcase_next),
    .held_color_next  (held_color_next),
    .line_active_next (line_active_next),
    .flags            (step_flags),
    .pixel_x          (step_x_pix),
    .pixel_y          (step_y_pix),
    .pixel_color      (step_color)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (in_fire) begin
      line_active <= line_active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      target_x   <= target_x_next;
      target_y   <= target_y_next;
      dx         <= dx_next;
      dy         <= dy_next;
      err        <= err_next;
      dcase      <= dcase_next;
      held_color <= held_color_next;
    end
  end

  lpw_result_reg #(
    .COORD_BITS(COORD_BITS)
  ) u_result (
    .clk         (clk),
    .rst         (rst),
    .load        (in_fire),
    .flags_in    (step_flags),
    .x_in        (step_x_pix),
    .y_in        (step_y_pix),
    .color_in    (step_color),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .flags       (out_flags),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color)
  );

  assign pixel_valid = out_flags.pixel_valid;
  assign last_pixel  = out_flags.last_pixel;

endmodule
